/* design/sper_pkg.sv */
`timescale 1ns / 1ps

package sper_pkg;

  // default sizing of the distance table
  localparam int MAX_NODES_DEF = 4096;
  localparam int DIST_BITS_DEF = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // operation codes as carried on the input channel
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RELAX = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_SUM  = 2'd1,
    B_CAP  = 2'd2,
    B_DONE = 2'd3
  } back_state_t;

  // classified command flags
  typedef struct packed {
    op_t  op;
    logic src_ok;
    logic dst_ok;
  } ctl_t;

  // queue status seen by front and back
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // back-end status
  typedef struct packed {
    back_state_t state;
    logic        pop;
  } back_stat_t;

  localparam int CMD_BITS_DEF = $bits(ctl_t) + 2 * $clog2(MAX_NODES_DEF) + DIST_BITS_DEF;

endpackage

/* design/sper_if.sv */
`timescale 1ns / 1ps

// input item channel
interface sper_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] source_node;
  logic [11:0] dest_node;
  logic [31:0] operand_value;

  modport source (output valid, opcode, source_node, dest_node, operand_value, input ready);
  modport sink   (input valid, opcode, source_node, dest_node, operand_value, output ready);
endinterface

// result item channel
interface sper_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance_out;
  logic        improved;
  logic [63:0] checksum_out;

  modport source (output valid, distance_out, improved, checksum_out, input ready);
  modport sink   (input valid, distance_out, improved, checksum_out, output ready);
endinterface

// unreached mark register write channel
interface sper_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* design/sper_front.sv */
`timescale 1ns / 1ps

module sper_front #(
  parameter int MAX_NODES = sper_pkg::MAX_NODES_DEF,
  parameter int DIST_BITS = sper_pkg::DIST_BITS_DEF
) (
  sper_in_if.sink                        in_item,
  input  sper_pkg::q_stat_t              q_stat,
  output logic                           push,
  output sper_pkg::ctl_t                 ctl,
  output logic [$clog2(MAX_NODES)-1:0]   src_addr,
  output logic [$clog2(MAX_NODES)-1:0]   dst_addr,
  output logic [DIST_BITS-1:0]           val
);

  localparam int ADDR_W = $clog2(MAX_NODES);

  // accept whenever the queue has room
  assign in_item.ready = !q_stat.full;
  assign push          = in_item.valid && !q_stat.full;

  // classify: decode op, check node indexes against table size
  always_comb begin
    ctl.op     = sper_pkg::op_t'(in_item.opcode);
    ctl.src_ok = 32'(in_item.source_node) < 32'(MAX_NODES);
    ctl.dst_ok = 32'(in_item.dest_node) < 32'(MAX_NODES);
  end

  // table addresses and operand trimmed to distance width
  assign src_addr = ADDR_W'(in_item.source_node);
  assign dst_addr = ADDR_W'(in_item.dest_node);
  assign val      = DIST_BITS'(in_item.operand_value);

endmodule

/* design/sper_queue.sv */
`timescale 1ns / 1ps

module sper_queue #(
  parameter int WIDTH = sper_pkg::CMD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              pop,
  output logic [WIDTH-1:0]  rdata,
  output sper_pkg::q_stat_t stat
);

  logic [WIDTH-1:0]               entries [sper_pkg::QUEUE_DEPTH];
  logic [sper_pkg::QPTR_W-1:0]    wr_ptr;
  logic [sper_pkg::QPTR_W-1:0]    rd_ptr;
  logic [sper_pkg::QCNT_W-1:0]    count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  assign rdata      = entries[rd_ptr];
  assign stat.valid = count != '0;
  assign stat.full  = count == sper_pkg::QCNT_W'(sper_pkg::QUEUE_DEPTH);

endmodule

/* design/sper_back.sv */
`timescale 1ns / 1ps

module sper_back #(
  parameter int MAX_NODES = sper_pkg::MAX_NODES_DEF,
  parameter int DIST_BITS = sper_pkg::DIST_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  sper_cfg_if.sink                       cfg,
  sper_out_if.source                     out_item,
  input  sper_pkg::q_stat_t              q_stat,
  input  sper_pkg::ctl_t                 h_ctl,
  input  logic [$clog2(MAX_NODES)-1:0]   h_src,
  input  logic [$clog2(MAX_NODES)-1:0]   h_dst,
  input  logic [DIST_BITS-1:0]           h_val,
  output logic                           pop,
  output sper_pkg::back_stat_t           stat
);

  localparam int ADDR_W = $clog2(MAX_NODES);

  sper_pkg::back_state_t state, state_next;

  // distance table
  logic [DIST_BITS-1:0] mem [MAX_NODES];
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [DIST_BITS-1:0] mem_wdata;

  // current command and its working values
  sper_pkg::ctl_t       cmd_ctl;
  logic [ADDR_W-1:0]    cmd_src;
  logic [ADDR_W-1:0]    cmd_dst;
  logic [DIST_BITS-1:0] cmd_val;
  logic [DIST_BITS-1:0] rd_src;
  logic [DIST_BITS-1:0] rd_dst;
  logic [DIST_BITS-1:0] sum_sat;
  logic [DIST_BITS-1:0] cap_val;
  logic [DIST_BITS:0]   add_full;

  logic [31:0]          unreached;
  logic [DIST_BITS-1:0] mark;
  logic [63:0]          checksum;
  logic [63:0]          checksum_res;
  logic [DIST_BITS-1:0] dist_res;
  logic                 improve;
  logic                 done_fire;

  logic                 out_valid;
  logic [31:0]          out_dist;
  logic                 out_imp;
  logic [63:0]          out_sum;

  assign mark = DIST_BITS'(unreached);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sper_pkg::B_IDLE;
      out_valid <= 1'b0;
      checksum  <= '0;
      unreached <= '1;
    end else begin
      state <= state_next;
      if (done_fire)          out_valid <= 1'b1;
      else if (out_item.ready) out_valid <= 1'b0;
      if (done_fire) checksum <= checksum_res;
      if (cfg.valid) unreached <= cfg.data;
    end
  end

  // sequencer: take command, add, cap, update and deliver
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    done_fire  = 1'b0;
    case (state)
      sper_pkg::B_IDLE: begin
        if (q_stat.valid) begin
          pop        = 1'b1;
          state_next = sper_pkg::B_SUM;
        end
      end
      sper_pkg::B_SUM: state_next = sper_pkg::B_CAP;
      sper_pkg::B_CAP: state_next = sper_pkg::B_DONE;
      sper_pkg::B_DONE: begin
        if (!out_valid || out_item.ready) begin
          done_fire  = 1'b1;
          state_next = sper_pkg::B_IDLE;
        end
      end
      default: state_next = sper_pkg::B_IDLE;
    endcase
  end

  // table read at both node addresses when the command is taken, single write port
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_src <= mem[h_src];
      rd_dst <= mem[h_dst];
    end
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  // latch command, then saturated sum, then cap below the unreached mark
  assign add_full = {1'b0, rd_src} + {1'b0, cmd_val};

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_ctl <= h_ctl;
      cmd_src <= h_src;
      cmd_dst <= h_dst;
      cmd_val <= h_val;
    end
    if (state == sper_pkg::B_SUM) begin
      sum_sat <= add_full[DIST_BITS] ? '1 : add_full[DIST_BITS-1:0];
    end
    if (state == sper_pkg::B_CAP) begin
      cap_val <= (mark != '0 && sum_sat >= mark) ? mark - 1'b1 : sum_sat;
    end
  end

  // result and table update
  always_comb begin
    improve = (cmd_ctl.op == sper_pkg::OP_RELAX) && cmd_ctl.src_ok && cmd_ctl.dst_ok
              && (rd_src != mark) && (rd_dst > cap_val);
    case (cmd_ctl.op)
      sper_pkg::OP_WRITE: dist_res = cmd_ctl.src_ok ? cmd_val : '0;
      sper_pkg::OP_RELAX: dist_res = (cmd_ctl.src_ok && cmd_ctl.dst_ok)
                                     ? (improve ? cap_val : rd_dst) : '0;
      sper_pkg::OP_READ:  dist_res = cmd_ctl.src_ok ? rd_src : '0;
      sper_pkg::OP_CLEAR: dist_res = '0;
      default:            dist_res = '0;
    endcase
    if (cmd_ctl.op == sper_pkg::OP_CLEAR) checksum_res = '0;
    else if (improve)                     checksum_res = checksum + 64'(cmd_val);
    else                                  checksum_res = checksum;
    mem_we    = done_fire && ((cmd_ctl.op == sper_pkg::OP_WRITE && cmd_ctl.src_ok) || improve);
    mem_waddr = (cmd_ctl.op == sper_pkg::OP_WRITE) ? cmd_src : cmd_dst;
    mem_wdata = (cmd_ctl.op == sper_pkg::OP_WRITE) ? cmd_val : cap_val;
  end

  // output register
  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_dist <= 32'(dist_res);
      out_imp  <= improve;
      out_sum  <= checksum_res;
    end
  end

  assign out_item.valid        = out_valid;
  assign out_item.distance_out = out_dist;
  assign out_item.improved     = out_imp;
  assign out_item.checksum_out = out_sum;
  assign cfg.ready             = 1'b1;

  assign stat.state = state;
  assign stat.pop   = pop;

endmodule

/* design/shortest_path_edge_relaxer_unit.sv */
`timescale 1ns / 1ps
// an item passes the queue, then the sequencer states B_IDLE, B_SUM, B_CAP and B_DONE
// the back-end sequencer finishes one item before it pops the next
//   (table read, saturating add, cap below unreached mark, table update)
// a 2-entry command queue lets input be taken while the back end is busy
// reset: synchronous, clears queue, sequencer, checksum; unreached mark to all ones
// the distance table is not cleared; entries are undefined until written

module shortest_path_edge_relaxer_unit #(
  parameter int MAX_NODES = sper_pkg::MAX_NODES_DEF,
  parameter int DIST_BITS = sper_pkg::DIST_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sper_cfg_if.sink   cfg,
  sper_in_if.sink    in_item,
  sper_out_if.source out_item
);

  localparam int ADDR_W = $clog2(MAX_NODES);
  localparam int CMD_W  = $bits(sper_pkg::ctl_t) + 2 * ADDR_W + DIST_BITS;

  sper_pkg::q_stat_t    q_stat;
  sper_pkg::back_stat_t b_stat;
  sper_pkg::ctl_t       f_ctl;
  sper_pkg::ctl_t       h_ctl;
  logic [ADDR_W-1:0]    f_src, f_dst, h_src, h_dst;
  logic [DIST_BITS-1:0] f_val, h_val;
  logic [CMD_W-1:0]     q_wdata, q_rdata;
  logic                 push;
  logic                 pop;

  // front: accept and classify
  sper_front #(
    .MAX_NODES (MAX_NODES),
    .DIST_BITS (DIST_BITS)
  ) u_front (
    .in_item  (in_item),
    .q_stat   (q_stat),
    .push     (push),
    .ctl      (f_ctl),
    .src_addr (f_src),
    .dst_addr (f_dst),
    .val      (f_val)
  );

  // command queue
  assign q_wdata = {f_ctl, f_src, f_dst, f_val};
  assign {h_ctl, h_src, h_dst, h_val} = q_rdata;

  sper_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: table access, relaxation, checksum, result
  sper_back #(
    .MAX_NODES (MAX_NODES),
    .DIST_BITS (DIST_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .out_item (out_item),
    .q_stat   (q_stat),
    .h_ctl    (h_ctl),
    .h_src    (h_src),
    .h_dst    (h_dst),
    .h_val    (h_val),
    .pop      (pop),
    .stat     (b_stat)
  );

  // back end never takes from an empty queue
  assert property (@(posedge clk) disable iff (rst) b_stat.pop |-> q_stat.valid)
    else $error("pop from empty command queue");

  // a taken command always moves on to the add step
  assert property (@(posedge clk) disable iff (rst)
    b_stat.pop |=> (b_stat.state == sper_pkg::B_SUM))
    else $error("sequencer did not start after pop");

  // an idle back end with queued work takes it at once
  assert property (@(posedge clk) disable iff (rst)
    (b_stat.state == sper_pkg::B_IDLE && q_stat.valid) |-> b_stat.pop)
    else $error("queued command left waiting");

  // input is refused only while the queue is full
  assert property (@(posedge clk) disable iff (rst)
    (in_item.valid && !in_item.ready) |-> q_stat.full)
    else $error("input stalled with room in queue");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

  // one operation as offered on the input channel
  typedef struct packed {
    sper_pkg::op_t op;
    logic [11:0]   src;
    logic [11:0]   dst;
    logic [31:0]   val;
  } op_item_t;

  // one result item
  typedef struct packed {
    logic [31:0] dval;
    logic        imp;
    logic [63:0] cks;
  } result_t;

  // directed row: item, whether the answer is typed in, typed answer
  typedef struct packed {
    op_item_t item;
    logic     typed;
    result_t  ans;
  } row_t;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 8;
  localparam int RAND_PER_PHASE = 155;

  logic clk = 1'b0;
  logic rst;

  sper_in_if  in_ch ();
  sper_out_if res_ch ();
  sper_cfg_if cfg_ch ();

  shortest_path_edge_relaxer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch),
    .in_item  (in_ch),
    .out_item (res_ch)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mirror of the block state
  logic [31:0] node_dist [sper_pkg::MAX_NODES_DEF];
  bit          node_loaded [sper_pkg::MAX_NODES_DEF];
  logic [11:0] loaded_nodes [$];
  logic [63:0] weight_sum;
  logic [31:0] unreached_mark;

  result_t     pending_results [$];
  int          err_cnt = 0;
  int          stall_cycles = 0;
  int          phase_id = 0;
  bit          burst = 1'b0;
  logic [11:0] pool [POOL_SIZE];

  // directed items, typed answers where they follow from reset state and the items before
  row_t dir_rows [22] = '{
    '{'{sper_pkg::OP_CLEAR, 12'h000, 12'h000, 32'h00000000}, 1'b1,
      '{32'h00000000, 1'b0, 64'h0}},
    '{'{sper_pkg::OP_WRITE, 12'h000, 12'hFFF, 32'h00000000}, 1'b1,
      '{32'h00000000, 1'b0, 64'h0}},
    '{'{sper_pkg::OP_WRITE, 12'hFFF, 12'h000, 32'hFFFFFFFF}, 1'b1,
      '{32'hFFFFFFFF, 1'b0, 64'h0}},
    '{'{sper_pkg::OP_READ,  12'h000, 12'hFFF, 32'hFFFFFFFF}, 1'b1,
      '{32'h00000000, 1'b0, 64'h0}},
    '{'{sper_pkg::OP_READ,  12'hFFF, 12'h000, 32'h00000000}, 1'b1,
      '{32'hFFFFFFFF, 1'b0, 64'h0}},
    '{'{sper_pkg::OP_RELAX, 12'hFFF, 12'h000, 32'h00000001}, 1'b1,
      '{32'h00000000, 1'b0, 64'h0}},
    '{'{sper_pkg::OP_RELAX, 12'h000, 12'hFFF, 32'hFFFFFFFF}, 1'b1,
      '{32'hFFFFFFFE, 1'b1, 64'h00000000FFFFFFFF}},
    '{'{sper_pkg::OP_WRITE, 12'hAAA, 12'h555, 32'h55555555}, 1'b1,
      '{32'h55555555, 1'b0, 64'h00000000FFFFFFFF}},
    '{'{sper_pkg::OP_WRITE, 12'h555, 12'hAAA, 32'hAAAAAAAA}, 1'b1,
      '{32'hAAAAAAAA, 1'b0, 64'h00000000FFFFFFFF}},
    '{'{sper_pkg::OP_RELAX, 12'hAAA, 12'h555, 32'h12345678}, 1'b0, '0},
    '{'{sper_pkg::OP_RELAX, 12'hAAA, 12'h555, 32'h12345678}, 1'b0, '0},
    '{'{sper_pkg::OP_RELAX, 12'h555, 12'hAAA, 32'h00000000}, 1'b0, '0},
    '{'{sper_pkg::OP_WRITE, 12'hFFF, 12'h000, 32'hFFFFFFFF}, 1'b0, '0},
    '{'{sper_pkg::OP_RELAX, 12'hFFF, 12'hAAA, 32'h00000000}, 1'b0, '0},
    '{'{sper_pkg::OP_RELAX, 12'h000, 12'h000, 32'h00000000}, 1'b0, '0},
    '{'{sper_pkg::OP_WRITE, 12'h001, 12'h000, 32'h00000005}, 1'b0, '0},
    '{'{sper_pkg::OP_RELAX, 12'h000, 12'h001, 32'h00000002}, 1'b0, '0},
    '{'{sper_pkg::OP_READ,  12'h001, 12'h000, 32'h00000000}, 1'b0, '0},
    '{'{sper_pkg::OP_CLEAR, 12'hFFF, 12'hFFF, 32'hFFFFFFFF}, 1'b1,
      '{32'h00000000, 1'b0, 64'h0}},
    '{'{sper_pkg::OP_RELAX, 12'hAAA, 12'hFFF, 32'hFFFFFFFF}, 1'b0, '0},
    '{'{sper_pkg::OP_READ,  12'hFFF, 12'h000, 32'h00000000}, 1'b0, '0},
    '{'{sper_pkg::OP_READ,  12'h555, 12'hFFF, 32'hFFFFFFFF}, 1'b0, '0}
  };

  // apply one operation to the mirrored table and checksum
  function automatic result_t apply_item(op_item_t it);
    result_t     r;
    logic [32:0] sum;
    logic [31:0] src_d;
    logic [31:0] dst_d;
    r = '0;
    case (it.op)
      sper_pkg::OP_WRITE: begin
        if (int'(it.src) < sper_pkg::MAX_NODES_DEF) begin
          node_dist[it.src] = it.val;
          if (!node_loaded[it.src]) begin
            node_loaded[it.src] = 1'b1;
            loaded_nodes.push_back(it.src);
          end
          r.dval = it.val;
        end
      end
      sper_pkg::OP_RELAX: begin
        if (int'(it.src) < sper_pkg::MAX_NODES_DEF &&
            int'(it.dst) < sper_pkg::MAX_NODES_DEF) begin
          src_d = node_dist[it.src];
          dst_d = node_dist[it.dst];
          if (src_d != unreached_mark) begin
            // saturate at all ones, then keep below the unreached mark
            sum = {1'b0, src_d} + {1'b0, it.val};
            if (sum[32]) sum = {1'b0, 32'hFFFFFFFF};
            if (unreached_mark != 32'd0 && sum[31:0] >= unreached_mark)
              sum = {1'b0, unreached_mark - 32'd1};
            if (dst_d > sum[31:0]) begin
              dst_d = sum[31:0];
              node_dist[it.dst] = dst_d;
              weight_sum = weight_sum + {32'd0, it.val};
              r.imp = 1'b1;
            end
          end
          r.dval = dst_d;
        end
      end
      sper_pkg::OP_READ: begin
        if (int'(it.src) < sper_pkg::MAX_NODES_DEF) r.dval = node_dist[it.src];
      end
      default: weight_sum = '0;
    endcase
    r.cks = weight_sum;
    return r;
  endfunction

  // offer one item, with random gaps ahead of it, and log its expected result
  task automatic send_item(input op_item_t it, input logic typed, input result_t ans);
    result_t r;
    while (!burst && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= it.op;
    in_ch.source_node   <= it.src;
    in_ch.dest_node     <= it.dst;
    in_ch.operand_value <= it.val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = apply_item(it);
    pending_results.push_back(typed ? ans : r);
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write the unreached mark; only called with the block drained
  task automatic write_mark(input logic [31:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid   <= 1'b0;
    unreached_mark = v;
  endtask

  function automatic logic [31:0] pick_dist();
    case ($urandom_range(5))
      0:       return unreached_mark;
      1:       return unreached_mark - 32'd1;
      2:       return 32'hFFFFFFFF;
      3:       return 32'($urandom_range(1000));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFFFFFF;
      2, 3:    return 32'($urandom_range(50));
      4:       return 32'($urandom_range(65536));
      default: return 32'($urandom);
    endcase
  endfunction

  // mostly the phase's small graph, sometimes any node already loaded
  function automatic logic [11:0] pick_node();
    if ($urandom_range(99) < 80) return pool[$urandom_range(POOL_SIZE - 1)];
    return loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
  endfunction

  // load a fresh small graph: one near source, the rest at mixed distances
  task automatic load_pool();
    op_item_t it;
    for (int j = 0; j < POOL_SIZE; j++) begin
      pool[j] = 12'($urandom);
      it.op  = sper_pkg::OP_WRITE;
      it.src = pool[j];
      it.dst = 12'($urandom);
      it.val = (j == 0) ? 32'($urandom_range(10)) : pick_dist();
      send_item(it, 1'b0, '0);
    end
  endtask

  // random mix: mostly relaxations over the graph, plus loads, reads and clears
  task automatic run_random(input int count);
    op_item_t it;
    int       k;
    for (int i = 0; i < count; i++) begin
      k      = $urandom_range(99);
      it.src = 12'($urandom);
      it.dst = 12'($urandom);
      it.val = 32'($urandom);
      if (k < 8) begin
        it.op  = sper_pkg::OP_WRITE;
        it.val = pick_dist();
      end else if (k < 18) begin
        it.op  = sper_pkg::OP_WRITE;
        it.src = pool[$urandom_range(POOL_SIZE - 1)];
        it.val = pick_dist();
      end else if (k < 70) begin
        it.op  = sper_pkg::OP_RELAX;
        it.src = pick_node();
        it.dst = pick_node();
        it.val = pick_weight();
      end else if (k < 94) begin
        it.op  = sper_pkg::OP_READ;
        it.src = pick_node();
      end else begin
        it.op  = sper_pkg::OP_CLEAR;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic report_bad(input string field, input logic [63:0] want,
                            input logic [63:0] got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch %s at %0t: expected %h got %h", field, $realtime, want, got);
  endtask

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_bad("unexpected result", 64'd0, res_ch.checksum_out);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.distance_out !== want.dval)
          report_bad("distance_out", 64'(want.dval), 64'(res_ch.distance_out));
        if (res_ch.improved !== want.imp)
          report_bad("improved", 64'(want.imp), 64'(res_ch.improved));
        if (res_ch.checksum_out !== want.cks)
          report_bad("checksum_out", want.cks, res_ch.checksum_out);
      end
    end
  end

  // result side ready: random stalls, one long hold-off, no stalls in burst phase
  initial begin : drain_side
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (phase_id == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (burst) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= 36);
      end
    end
  end

  // watchdog on cycles with no item moving on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // main sequence
  initial begin : stimulus
    logic [31:0] marks [6];
    marks = '{32'h00000000, 32'h80000000, 32'd1000, 32'd1, 32'($urandom), 32'hFFFFFFFF};
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = sper_pkg::OP_WRITE;
    in_ch.source_node   = '0;
    in_ch.dest_node     = '0;
    in_ch.operand_value = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    weight_sum          = '0;
    unreached_mark      = 32'hFFFFFFFF;
    for (int n = 0; n < sper_pkg::MAX_NODES_DEF; n++) begin
      node_dist[n]   = '0;
      node_loaded[n] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items under the reset mark
    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].ans);
    load_pool();
    run_random(RAND_PER_PHASE);

    // one phase per mark setting
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_mark(marks[p]);
      phase_id <= p + 1;
      burst    <= (p == 2);
      load_pool();
      run_random(RAND_PER_PHASE);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
design/sper_pkg.sv
design/sper_if.sv
design/sper_front.sv
design/sper_queue.sv
design/sper_back.sv
design/shortest_path_edge_relaxer_unit.sv
tb/sv/tb.sv
